// ----- sv/rpcf_pkg.sv -----
// ---------------------------------------------------------------------------
// rpcf_pkg
// shared widths, constants, types and the cordic arctangent table
// ---------------------------------------------------------------------------
package rpcf_pkg;

  localparam int DATA_W   = 32;
  localparam int LEN_W    = 31;
  localparam int ANG_W    = 16;
  localparam int TERM_W   = 33;
  localparam int SUM_W    = 50;
  localparam int ATAN_N   = 30;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int COORD_WIDTH_DEF       = 32;

  localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_x;
    logic signed [DATA_W-1:0] c_y;
    logic signed [DATA_W-1:0] c_z;
    logic [LEN_W-1:0]         len;
    logic [LEN_W-1:0]         wid;
  } rpcf_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_x;
    logic signed [DATA_W-1:0] c_y;
    logic signed [DATA_W-1:0] c_z;
    logic signed [TERM_W-1:0] lt_x;
    logic signed [TERM_W-1:0] lt_y;
    logic signed [TERM_W-1:0] lt_z;
    logic signed [TERM_W-1:0] wt_x;
    logic signed [TERM_W-1:0] wt_y;
    logic signed [TERM_W-1:0] wt_z;
  } rpcf_terms_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [DATA_W-1:0] atan_turn32(input logic [4:0] idx);
    logic [DATA_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/rpcf_in_if.sv -----
// ---------------------------------------------------------------------------
// rpcf_in_if
// patch input channel: valid/ready with one patch per word
// ---------------------------------------------------------------------------
interface rpcf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rpcf_pkg::DATA_W-1:0]      center_x;
  logic signed [rpcf_pkg::DATA_W-1:0]      center_y;
  logic signed [rpcf_pkg::DATA_W-1:0]      center_z;
  logic [rpcf_pkg::LEN_W-1:0]              patch_length;
  logic [rpcf_pkg::LEN_W-1:0]              patch_width;
  logic [rpcf_pkg::ANG_W-1:0]              strike_angle;
  logic [rpcf_pkg::ANG_W-1:0]              dip_angle;

  modport source (
    output valid, center_x, center_y, center_z, patch_length, patch_width,
           strike_angle, dip_angle,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, patch_length, patch_width,
           strike_angle, dip_angle,
    output ready
  );
endinterface

// ----- sv/rpcf_out_if.sv -----
// ---------------------------------------------------------------------------
// rpcf_out_if
// corner output channel: valid/ready with one corner per word
// ---------------------------------------------------------------------------
interface rpcf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              corner_index;
  logic signed [rpcf_pkg::DATA_W-1:0]      corner_x;
  logic signed [rpcf_pkg::DATA_W-1:0]      corner_y;
  logic signed [rpcf_pkg::DATA_W-1:0]      corner_z;
  logic                                    last_corner;

  modport source (
    output valid, corner_index, corner_x, corner_y, corner_z, last_corner,
    input  ready
  );
  modport sink (
    input  valid, corner_index, corner_x, corner_y, corner_z, last_corner,
    output ready
  );
endinterface

// ----- sv/rpcf_cordic.sv -----
// ---------------------------------------------------------------------------
// rpcf_cordic
// pipelined rotation cordic: sine and cosine of a 16-bit binary angle,
// one iteration per stage, outputs scaled by 2^30, so magnitudes stay below 2
// ---------------------------------------------------------------------------
module rpcf_cordic #(
  parameter int ITERATIONS = rpcf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [rpcf_pkg::ANG_W-1:0]          angle,
  output logic signed [rpcf_pkg::DATA_W-1:0]  sin_val,
  output logic signed [rpcf_pkg::DATA_W-1:0]  cos_val
);

  localparam int DW = rpcf_pkg::DATA_W;

  logic [DW-1:0]          phase;
  logic                   flip;
  logic signed [DW-1:0]   z_r    [0:ITERATIONS];
  logic                   flip_r [0:ITERATIONS];
  logic signed [DW-1:0]   x_r    [1:ITERATIONS];
  logic signed [DW-1:0]   y_r    [1:ITERATIONS];
  logic signed [DW-1:0]   sin_r;
  logic signed [DW-1:0]   cos_r;

  // fold into [-90, +90) degrees
  always_comb begin
    phase = {angle, {(DW-rpcf_pkg::ANG_W){1'b0}}};
    flip  = phase[DW-1] ^ phase[DW-2];
    if (flip) begin
      phase[DW-1] = ~phase[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]    <= $signed(phase);
      flip_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic signed [DW-1:0] ATAN = rpcf_pkg::atan_turn32(5'(i));
    logic signed [DW-1:0] x_in;
    logic signed [DW-1:0] y_in;

    if (i == 0) begin : g_first
      assign x_in = rpcf_pkg::CORDIC_GAIN;
      assign y_in = '0;
    end else begin : g_next
      assign x_in = x_r[i];
      assign y_in = y_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][DW-1]) begin
          x_r[i+1] <= x_in - (y_in >>> i);
          y_r[i+1] <= y_in + (x_in >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_in + (y_in >>> i);
          y_r[i+1] <= y_in - (x_in >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[ITERATIONS]) begin
        sin_r <= -y_r[ITERATIONS];
        cos_r <= -x_r[ITERATIONS];
      end else begin
        sin_r <= y_r[ITERATIONS];
        cos_r <= x_r[ITERATIONS];
      end
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

// ----- sv/rpcf_proj.sv -----
// ---------------------------------------------------------------------------
// rpcf_proj
// two multiply stages: down-dip vector, then the half length and half width
// terms along both unit vectors
// ---------------------------------------------------------------------------
module rpcf_proj (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_in,
  input  rpcf_pkg::rpcf_item_t                item,
  input  logic signed [rpcf_pkg::DATA_W-1:0]  sin_s,
  input  logic signed [rpcf_pkg::DATA_W-1:0]  cos_s,
  input  logic signed [rpcf_pkg::DATA_W-1:0]  sin_d,
  input  logic signed [rpcf_pkg::DATA_W-1:0]  cos_d,
  output logic                                vld_out,
  output rpcf_pkg::rpcf_terms_t               terms
);

  localparam int DW = rpcf_pkg::DATA_W;
  localparam int TW = rpcf_pkg::TERM_W;

  logic                  vld_a_r;
  logic                  vld_b_r;
  rpcf_pkg::rpcf_item_t  item_a_r;
  logic signed [DW-1:0]  st_x_r;
  logic signed [DW-1:0]  st_y_r;
  logic signed [DW-1:0]  dd_x_r;
  logic signed [DW-1:0]  dd_y_r;
  logic signed [DW-1:0]  dd_z_r;
  logic signed [DW-1:0]  dd_x_nxt;
  logic signed [DW-1:0]  dd_y_nxt;
  logic signed [63:0]    pcx;
  logic signed [63:0]    pcy;
  rpcf_pkg::rpcf_terms_t terms_r;
  rpcf_pkg::rpcf_terms_t terms_nxt;

  function automatic logic signed [TW-1:0] half_term(
    input logic [rpcf_pkg::LEN_W-1:0] len,
    input logic signed [DW-1:0]       unit
  );
    logic signed [63:0] p;
    p = $signed({1'b0, len}) * unit;
    p = p + 64'sd1073741824;
    return p[31+TW-1:31];
  endfunction

  always_comb begin
    pcx      = cos_d * cos_s + 64'sd536870912;
    pcy      = cos_d * sin_s + 64'sd536870912;
    dd_x_nxt = pcx[30+DW-1:30];
    dd_y_nxt = -pcy[30+DW-1:30];
  end

  always_comb begin
    terms_nxt.c_x  = item_a_r.c_x;
    terms_nxt.c_y  = item_a_r.c_y;
    terms_nxt.c_z  = item_a_r.c_z;
    terms_nxt.lt_x = half_term(item_a_r.len, st_x_r);
    terms_nxt.lt_y = half_term(item_a_r.len, st_y_r);
    terms_nxt.lt_z = '0;
    terms_nxt.wt_x = half_term(item_a_r.wid, dd_x_r);
    terms_nxt.wt_y = half_term(item_a_r.wid, dd_y_r);
    terms_nxt.wt_z = half_term(item_a_r.wid, dd_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_a_r <= item;
      st_x_r   <= sin_s;
      st_y_r   <= cos_s;
      dd_x_r   <= dd_x_nxt;
      dd_y_r   <= dd_y_nxt;
      dd_z_r   <= -sin_d;
      terms_r  <= terms_nxt;
    end
  end

  assign vld_out = vld_b_r;
  assign terms   = terms_r;

endmodule

// ----- sv/rpcf_corner_ser.sv -----
// ---------------------------------------------------------------------------
// rpcf_corner_ser
// holds one patch's terms and sends its four corners, one word per cycle
// while the output channel accepts, through a registered output
// ---------------------------------------------------------------------------
module rpcf_corner_ser #(
  parameter int COORD_WIDTH = rpcf_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  rpcf_pkg::rpcf_terms_t   terms,
  output logic                    ready,
  rpcf_out_if.source              out_port
);

  localparam int DW = rpcf_pkg::DATA_W;
  localparam int TW = rpcf_pkg::TERM_W;
  localparam int SW = rpcf_pkg::SUM_W;
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << (COORD_WIDTH-1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  rpcf_pkg::rpcf_terms_t hold_r;
  logic                  busy_r;
  logic [1:0]            k_r;
  logic                  out_vld_r;
  logic [1:0]            idx_r;
  logic signed [DW-1:0]  cx_r;
  logic signed [DW-1:0]  cy_r;
  logic signed [DW-1:0]  cz_r;
  logic                  last_r;
  logic                  step;
  logic                  neg_l;
  logic                  neg_w;

  function automatic logic signed [DW-1:0] corner(
    input logic signed [DW-1:0] c,
    input logic signed [TW-1:0] lt,
    input logic signed [TW-1:0] wt,
    input logic                 nl,
    input logic                 nw
  );
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] w;
    l = {{(SW-TW){lt[TW-1]}}, lt};
    w = {{(SW-TW){wt[TW-1]}}, wt};
    s = {{(SW-DW){c[DW-1]}}, c} + (nl ? -l : l) + (nw ? -w : w);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[DW-1:0];
  endfunction

  always_comb begin
    step  = busy_r && (!out_vld_r || out_port.ready);
    ready = !busy_r || (step && (k_r == 2'd3));
    neg_l = (k_r == 2'd0) || (k_r == 2'd3);
    neg_w = k_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_port.ready) begin
        out_vld_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (step) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= terms;
    end
    if (step) begin
      idx_r  <= k_r;
      last_r <= (k_r == 2'd3);
      cx_r   <= corner(hold_r.c_x, hold_r.lt_x, hold_r.wt_x, neg_l, neg_w);
      cy_r   <= corner(hold_r.c_y, hold_r.lt_y, hold_r.wt_y, neg_l, neg_w);
      cz_r   <= corner(hold_r.c_z, hold_r.lt_z, hold_r.wt_z, neg_l, neg_w);
    end
  end

  assign out_port.valid        = out_vld_r;
  assign out_port.corner_index = idx_r;
  assign out_port.corner_x     = cx_r;
  assign out_port.corner_y     = cy_r;
  assign out_port.corner_z     = cz_r;
  assign out_port.last_corner  = last_r;

endmodule

// ----- sv/rect_patch_corner_finder.sv -----
// ---------------------------------------------------------------------------
// rect_patch_corner_finder
// four corners of a rectangular fault patch from center, size, strike, dip
//
//   channel    dir  word
//   in_port    in   one patch: center, length, width, strike, dip
//   out_port   out  one corner: index, x, y, z, last flag
//
// one patch per four corner words, set by the single output port (four corners)
// reset is synchronous, active low, and clears all valid bits
// the whole pipeline holds while the corner stage is full and stalled
// ---------------------------------------------------------------------------
module rect_patch_corner_finder #(
  parameter int CORDIC_ITERATIONS = rpcf_pkg::CORDIC_ITERATIONS_DEF,
  parameter int COORD_WIDTH       = rpcf_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rpcf_in_if.sink     in_port,
  rpcf_out_if.source  out_port
);

  localparam int LAT = CORDIC_ITERATIONS + 2;
  localparam int DW  = rpcf_pkg::DATA_W;

  logic                  en;
  logic                  ser_ready;
  logic                  proj_vld;
  logic                  vld_r  [0:LAT-1];
  rpcf_pkg::rpcf_item_t  item_r [0:LAT-1];
  rpcf_pkg::rpcf_item_t  item_in;
  rpcf_pkg::rpcf_terms_t terms;
  logic signed [DW-1:0]  sin_s;
  logic signed [DW-1:0]  cos_s;
  logic signed [DW-1:0]  sin_d;
  logic signed [DW-1:0]  cos_d;

  assign en            = !proj_vld || ser_ready;
  assign in_port.ready = en;

  always_comb begin
    item_in.c_x = in_port.center_x;
    item_in.c_y = in_port.center_y;
    item_in.c_z = in_port.center_z;
    item_in.len = in_port.patch_length;
    item_in.wid = in_port.patch_width;
  end

  for (genvar i = 0; i < LAT; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        if (i == 0) begin
          vld_r[i] <= in_port.valid;
        end else begin
          vld_r[i] <= vld_r[(i == 0) ? 0 : i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          item_r[i] <= item_in;
        end else begin
          item_r[i] <= item_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  rpcf_cordic #(
    .ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic_strike (
    .clk     (clk),
    .en      (en),
    .angle   (in_port.strike_angle),
    .sin_val (sin_s),
    .cos_val (cos_s)
  );

  rpcf_cordic #(
    .ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic_dip (
    .clk     (clk),
    .en      (en),
    .angle   (in_port.dip_angle),
    .sin_val (sin_d),
    .cos_val (cos_d)
  );

  rpcf_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld_r[LAT-1]),
    .item    (item_r[LAT-1]),
    .sin_s   (sin_s),
    .cos_s   (cos_s),
    .sin_d   (sin_d),
    .cos_d   (cos_d),
    .vld_out (proj_vld),
    .terms   (terms)
  );

  rpcf_corner_ser #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (proj_vld && ser_ready),
    .terms    (terms),
    .ready    (ser_ready),
    .out_port (out_port)
  );

endmodule

// ----- test/tb_rpcf_chk.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rpcf_chk
// corner prediction for the fault patch corner finder, used by tb
// ---------------------------------------------------------------------------
package tb_rpcf_chk;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } corner_t;

  localparam int N_STEP = (rpcf_pkg::CORDIC_ITERATIONS_DEF > rpcf_pkg::ATAN_N) ?
                          rpcf_pkg::ATAN_N : rpcf_pkg::CORDIC_ITERATIONS_DEF;

  const longint arctan_tbl [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  function automatic void rot_sincos(input logic [15:0] ang, output longint sn,
                                     output longint cs);
    logic [31:0] ph;
    logic        flip;
    longint      x, y, z, dx, dy;
    ph   = {ang, 16'h0};
    flip = ph[31] ^ ph[30];
    if (flip) ph[31] = ~ph[31];
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < N_STEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tbl[i];
      end else begin
        x += dx; y -= dy; z += arctan_tbl[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = y;
    cs = x;
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint hi;
    hi = (longint'(1) <<< (rpcf_pkg::COORD_WIDTH_DEF - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void patch_corners(input logic signed [31:0] cx, cy, cz,
                                        input logic [30:0] len, wid,
                                        input logic [15:0] strike, dip,
                                        output corner_t c [4]);
    longint ss, cs, sd, cd, l, w, v;
    longint ctr [3], st [3], dd [3], lt [3], wt [3];
    int sl, sw;
    rot_sincos(strike, ss, cs);
    rot_sincos(dip, sd, cd);
    ctr[0] = cx; ctr[1] = cy; ctr[2] = cz;
    l = longint'(len);
    w = longint'(wid);
    st[0] = ss; st[1] = cs; st[2] = 0;
    dd[0] = (cd * cs + (longint'(1) <<< 29)) >>> 30;
    dd[1] = -((cd * ss + (longint'(1) <<< 29)) >>> 30);
    dd[2] = -sd;
    for (int i = 0; i < 3; i++) begin
      lt[i] = (l * st[i] + (longint'(1) <<< 30)) >>> 31;
      wt[i] = (w * dd[i] + (longint'(1) <<< 30)) >>> 31;
    end
    for (int k = 0; k < 4; k++) begin
      sl = (k == 1 || k == 2) ? 1 : -1;
      sw = (k < 2) ? 1 : -1;
      c[k].idx  = k[1:0];
      c[k].last = (k == 3);
      for (int i = 0; i < 3; i++) begin
        v = clamp_coord(ctr[i] + sl * lt[i] + sw * wt[i]);
        if (i == 0) c[k].x = v[31:0];
        else if (i == 1) c[k].y = v[31:0];
        else c[k].z = v[31:0];
      end
    end
  endfunction

endpackage

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives fault patches into the corner finder and checks every corner word
// against a predictor; stalls are random on both channels, forced on output
// ---------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rpcf_in_if  in_ch ();
  rpcf_out_if out_ch ();

  rect_patch_corner_finder uut (
    .clk(clk), .rst_n(rst_n), .in_port(in_ch.sink), .out_port(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tb_rpcf_chk::corner_t corners_due [$];
  int n_err = 0;
  int n_patch = 0;
  int n_corner = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.center_z = '0;
    in_ch.patch_length = '0; in_ch.patch_width = '0;
    in_ch.strike_angle = '0; in_ch.dip_angle = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    tb_rpcf_chk::corner_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_corner++;
      if (corners_due.size() == 0) begin
        $display("%0t unexpected corner idx=%0d x=%h y=%h z=%h", $time,
                 out_ch.corner_index, out_ch.corner_x, out_ch.corner_y,
                 out_ch.corner_z);
        n_err++;
      end else begin
        e = corners_due.pop_front();
        if (out_ch.corner_index !== e.idx || out_ch.corner_x !== e.x ||
            out_ch.corner_y !== e.y || out_ch.corner_z !== e.z ||
            out_ch.last_corner !== e.last) begin
          $display("%0t corner mismatch exp idx=%0d x=%h y=%h z=%h last=%b",
                   $time, e.idx, e.x, e.y, e.z, e.last);
          $display("%0t                 got idx=%0d x=%h y=%h z=%h last=%b",
                   $time, out_ch.corner_index, out_ch.corner_x, out_ch.corner_y,
                   out_ch.corner_z, out_ch.last_corner);
          n_err++;
        end
      end
    end
  end

  task automatic send_patch(input logic [31:0] cx, cy, cz, input logic [30:0] len, wid,
                            input logic [15:0] strike, dip);
    tb_rpcf_chk::corner_t c [4];
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.center_x <= cx; in_ch.center_y <= cy; in_ch.center_z <= cz;
    in_ch.patch_length <= len; in_ch.patch_width <= wid;
    in_ch.strike_angle <= strike; in_ch.dip_angle <= dip;
    do @(posedge clk); while (!in_ch.ready);
    tb_rpcf_chk::patch_corners(cx, cy, cz, len, wid, strike, dip, c);
    for (int k = 0; k < 4; k++) corners_due.push_back(c[k]);
    n_patch++;
  endtask

  task automatic drain_corners();
    in_ch.valid <= 1'b0;
    while (corners_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_patch();
    logic [31:0] cx, cy, cz;
    logic [30:0] len, wid;
    logic [15:0] ang [2];
    cx = $urandom; cy = $urandom; cz = $urandom;
    len = 31'($urandom); wid = 31'($urandom);
    if ($urandom_range(3) != 0) begin
      cx = $signed(cx) >>> $urandom_range(31, 8);
      cy = $signed(cy) >>> $urandom_range(31, 8);
      cz = $signed(cz) >>> $urandom_range(31, 8);
      len = len >> $urandom_range(30, 8);
      wid = wid >> $urandom_range(30, 8);
    end
    for (int i = 0; i < 2; i++) begin
      ang[i] = 16'($urandom);
      if ($urandom_range(7) == 0)
        ang[i] = 16'({2'($urandom_range(3)), 14'h0} + $urandom_range(2) - 1);
    end
    send_patch(cx, cy, cz, len, wid, ang[0], ang[1]);
  endtask

  task automatic test_directed();
    send_patch(0, 0, 0, 0, 0, 0, 0);
    send_patch(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_4000, 31'h0000_2000,
               16'h0000, 16'h2000);
    for (int q = 0; q < 4; q++)
      send_patch(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 16'(q * 16'h4000),
                 16'(q * 16'h4000));
    send_patch(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               16'h2000, 16'h2000);
    send_patch(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               16'hA000, 16'hE000);
    send_patch(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 31'h7FFF_FFFF, 0,
               16'hFFFF, 16'hFFFF);
    send_patch(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 16'h3FFF, 16'h4001);
    send_patch(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 31'h5555_5555, 31'h2AAA_AAAA,
               16'h5555, 16'hAAAA);
    send_patch(32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987, 31'h2AAA_AAAA, 31'h5555_5555,
               16'hAAAA, 16'h5555);
    send_patch(0, 0, 0, 31'h0000_1000, 31'h0000_1000, 16'hC000, 16'h8000);
    send_patch(0, 0, 0, 31'h0000_0001, 31'h0000_0001, 16'h7FFF, 16'h8001);
    drain_corners();
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) random_patch();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    hold_cycles <= 120;
    repeat (40) random_patch();
    drain_corners();
    repeat (10) random_patch();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(110, 29, 84);
    test_random(110, 84, 29);
    test_backpressure();
    test_random(100, 0, 0);
    drain_corners();
    repeat (40) @(posedge clk);
    $display("tb: %0d patches sent, %0d corner words checked under random and forced stalls",
             n_patch, n_corner);
    if (n_err == 0 && corners_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: timeout");
    $display("tb: errors");
    $finish;
  end

endmodule
